// ----- design/ldpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ldpm_pkg
// Shared types, register indexes and Q4.28 arithmetic helpers for the
// lens distortion point map.
// ----------------------------------------------------------------------------
`default_nettype none

package ldpm_pkg;

    localparam int DIV_STAGES    = 8;
    localparam int DIV_STEPS     = 4;
    localparam int NORM_LATENCY  = DIV_STAGES + 2;
    localparam int POLY_LATENCY  = 8;
    localparam int PROJ_LATENCY  = 2;
    localparam int TOTAL_LATENCY = NORM_LATENCY + POLY_LATENCY + PROJ_LATENCY;

    localparam logic signed [31:0] Q28_ONE = 32'sh1000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [31:0] FOCAL_RESET = 32'd32768000;
    localparam logic [63:0] PP_RESET    = 64'd67553994431528960;

    typedef enum logic [3:0] {
        CFG_FOCAL_X = 4'd0,
        CFG_FOCAL_Y = 4'd1,
        CFG_PP      = 4'd2,
        CFG_K1      = 4'd3,
        CFG_K2      = 4'd4,
        CFG_K3      = 4'd5,
        CFG_P1      = 4'd6,
        CFG_P2      = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               saturated;
    } t_out_req;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    typedef struct packed {
        logic signed [31:0] v;
        logic               sat;
    } t_q;

    function automatic t_q sat32(input logic signed [39:0] v);
        t_q r;
        if (v > 40'(S32_MAX)) begin
            r.v   = S32_MAX;
            r.sat = 1'b1;
        end else if (v < 40'(S32_MIN)) begin
            r.v   = S32_MIN;
            r.sat = 1'b1;
        end else begin
            r.v   = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_q mulq(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [35:0] s;
        p = a * b;
        s = p[63:28];
        return sat32({{4{s[35]}}, s});
    endfunction

    function automatic t_q addq(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat32({{7{s[32]}}, s});
    endfunction

endpackage

`default_nettype wire

// ----- design/ldpm_norm.sv -----
// ----------------------------------------------------------------------------
// ldpm_norm
// Pipelined normalization of one axis: (in - c) * 2^28 / f with
// truncation toward zero and saturation to signed Q4.28.
// ----------------------------------------------------------------------------
`default_nettype none

module ldpm_norm (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_in,
    input  wire logic        [31:0] i_c,
    input  wire logic        [31:0] i_f,
    output ldpm_pkg::t_q            o_q
);

    logic [31:0] r_rem  [0:ldpm_pkg::DIV_STAGES];
    logic [31:0] r_quo  [0:ldpm_pkg::DIV_STAGES];
    logic [3:0]  r_nib  [0:ldpm_pkg::DIV_STAGES];
    logic        r_neg  [0:ldpm_pkg::DIV_STAGES];
    logic        r_ovf  [0:ldpm_pkg::DIV_STAGES];
    logic        r_zero [0:ldpm_pkg::DIV_STAGES];
    ldpm_pkg::t_q r_q;
    ldpm_pkg::t_q n_q;

    logic signed [33:0] n_d;
    logic        [32:0] n_mag;

    // front: difference, magnitude and quotient overflow
    always_comb begin
        n_d   = {{2{i_in[31]}}, i_in} - {2'b00, i_c};
        n_mag = n_d[33] ? 33'(-n_d) : n_d[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {3'b000, n_mag[32:4]};
            r_quo[0]  <= '0;
            r_nib[0]  <= n_mag[3:0];
            r_neg[0]  <= n_d[33];
            r_zero[0] <= (n_mag == '0);
            r_ovf[0]  <= ({3'b000, n_mag} >= {i_f, 4'b0000});
        end
    end

    // restoring division, a few quotient bits per stage
    for (genvar s = 1; s <= ldpm_pkg::DIV_STAGES; s++) begin : g_div
        logic [31:0] n_rem;
        logic [31:0] n_quo;

        always_comb begin
            logic [32:0] t;
            logic        b;
            n_rem = r_rem[s-1];
            n_quo = r_quo[s-1];
            for (int j = 0; j < ldpm_pkg::DIV_STEPS; j++) begin
                b = (s == 1) ? r_nib[s-1][ldpm_pkg::DIV_STEPS-1-j] : 1'b0;
                t = {n_rem, b};
                if (t >= {1'b0, i_f}) begin
                    t     = t - {1'b0, i_f};
                    n_quo = {n_quo[30:0], 1'b1};
                end else begin
                    n_quo = {n_quo[30:0], 1'b0};
                end
                n_rem = t[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_nib[s]  <= r_nib[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    // sign and saturation
    always_comb begin
        n_q.v   = r_quo[ldpm_pkg::DIV_STAGES];
        n_q.sat = 1'b0;
        if (r_zero[ldpm_pkg::DIV_STAGES]) begin
            n_q.v = '0;
        end else if (r_ovf[ldpm_pkg::DIV_STAGES]) begin
            n_q.v   = r_neg[ldpm_pkg::DIV_STAGES] ? ldpm_pkg::S32_MIN : ldpm_pkg::S32_MAX;
            n_q.sat = 1'b1;
        end else if (!r_neg[ldpm_pkg::DIV_STAGES]) begin
            if (r_quo[ldpm_pkg::DIV_STAGES][31]) begin
                n_q.v   = ldpm_pkg::S32_MAX;
                n_q.sat = 1'b1;
            end
        end else if (r_quo[ldpm_pkg::DIV_STAGES] > 32'h8000_0000) begin
            n_q.v   = ldpm_pkg::S32_MIN;
            n_q.sat = 1'b1;
        end else begin
            n_q.v = -r_quo[ldpm_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- design/ldpm_poly.sv -----
// ----------------------------------------------------------------------------
// ldpm_poly
// Radial and tangential distortion of a normalized point, pipelined as a
// chain of registered multiply and add stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ldpm_poly (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    input  wire logic               i_sat,
    input  ldpm_pkg::t_coef         i_coef,
    output logic signed [31:0]      o_xd,
    output logic signed [31:0]      o_yd,
    output logic                    o_sat
);

    // stage 1
    ldpm_pkg::t_q n1_x2, n1_y2, n1_xy;
    logic signed [31:0] r1_x, r1_y, r1_x2, r1_y2, r1_xy;
    logic r1_sat;
    // stage 2
    ldpm_pkg::t_q n2_txy, n2_r2, n2_ax, n2_ay;
    logic signed [31:0] r2_x, r2_y, r2_txy, r2_r2, r2_ax, r2_ay;
    logic r2_sat;
    // stage 3
    ldpm_pkg::t_q n3_r4, n3_k1r2, n3_tx, n3_ty;
    logic signed [31:0] r3_x, r3_y, r3_txy, r3_r2, r3_r4, r3_k1r2, r3_tx, r3_ty;
    logic r3_sat;
    // stage 4
    ldpm_pkg::t_q n4_r6, n4_k2r4, n4_rad1, n4_p1txy, n4_p2tx, n4_p1ty, n4_p2txy;
    logic signed [31:0] r4_x, r4_y, r4_r6, r4_k2r4, r4_rad1;
    logic signed [31:0] r4_p1txy, r4_p2tx, r4_p1ty, r4_p2txy;
    logic r4_sat;
    // stage 5
    ldpm_pkg::t_q n5_k3r6, n5_rad2;
    logic signed [31:0] r5_x, r5_y, r5_k3r6, r5_rad2;
    logic signed [31:0] r5_p1txy, r5_p2tx, r5_p1ty, r5_p2txy;
    logic r5_sat;
    // stage 6
    ldpm_pkg::t_q n6_rad;
    logic signed [31:0] r6_x, r6_y, r6_rad;
    logic signed [31:0] r6_p1txy, r6_p2tx, r6_p1ty, r6_p2txy;
    logic r6_sat;
    // stage 7
    ldpm_pkg::t_q n7_xr, n7_yr;
    logic signed [31:0] r7_xr, r7_yr;
    logic signed [31:0] r7_p1txy, r7_p2tx, r7_p1ty, r7_p2txy;
    logic r7_sat;
    // stage 8
    ldpm_pkg::t_q n8_xa, n8_xd, n8_ya, n8_yd;
    logic signed [31:0] r8_xd, r8_yd;
    logic r8_sat;

    always_comb begin
        n1_x2 = ldpm_pkg::mulq(i_x, i_x);
        n1_y2 = ldpm_pkg::mulq(i_y, i_y);
        n1_xy = ldpm_pkg::mulq(i_x, i_y);

        n2_txy = ldpm_pkg::addq(r1_xy, r1_xy);
        n2_r2  = ldpm_pkg::addq(r1_x2, r1_y2);
        n2_ax  = ldpm_pkg::addq(r1_x2, r1_x2);
        n2_ay  = ldpm_pkg::addq(r1_y2, r1_y2);

        n3_r4   = ldpm_pkg::mulq(r2_r2, r2_r2);
        n3_k1r2 = ldpm_pkg::mulq(i_coef.k1, r2_r2);
        n3_tx   = ldpm_pkg::addq(r2_r2, r2_ax);
        n3_ty   = ldpm_pkg::addq(r2_r2, r2_ay);

        n4_r6    = ldpm_pkg::mulq(r3_r4, r3_r2);
        n4_k2r4  = ldpm_pkg::mulq(i_coef.k2, r3_r4);
        n4_rad1  = ldpm_pkg::addq(ldpm_pkg::Q28_ONE, r3_k1r2);
        n4_p1txy = ldpm_pkg::mulq(i_coef.p1, r3_txy);
        n4_p2tx  = ldpm_pkg::mulq(i_coef.p2, r3_tx);
        n4_p1ty  = ldpm_pkg::mulq(i_coef.p1, r3_ty);
        n4_p2txy = ldpm_pkg::mulq(i_coef.p2, r3_txy);

        n5_k3r6 = ldpm_pkg::mulq(i_coef.k3, r4_r6);
        n5_rad2 = ldpm_pkg::addq(r4_rad1, r4_k2r4);

        n6_rad = ldpm_pkg::addq(r5_rad2, r5_k3r6);

        n7_xr = ldpm_pkg::mulq(r6_x, r6_rad);
        n7_yr = ldpm_pkg::mulq(r6_y, r6_rad);

        n8_xa = ldpm_pkg::addq(r7_xr, r7_p1txy);
        n8_xd = ldpm_pkg::addq(n8_xa.v, r7_p2tx);
        n8_ya = ldpm_pkg::addq(r7_yr, r7_p1ty);
        n8_yd = ldpm_pkg::addq(n8_ya.v, r7_p2txy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= i_x;
            r1_y   <= i_y;
            r1_x2  <= n1_x2.v;
            r1_y2  <= n1_y2.v;
            r1_xy  <= n1_xy.v;
            r1_sat <= i_sat | n1_x2.sat | n1_y2.sat | n1_xy.sat;

            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_txy <= n2_txy.v;
            r2_r2  <= n2_r2.v;
            r2_ax  <= n2_ax.v;
            r2_ay  <= n2_ay.v;
            r2_sat <= r1_sat | n2_txy.sat | n2_r2.sat | n2_ax.sat | n2_ay.sat;

            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_txy  <= r2_txy;
            r3_r2   <= r2_r2;
            r3_r4   <= n3_r4.v;
            r3_k1r2 <= n3_k1r2.v;
            r3_tx   <= n3_tx.v;
            r3_ty   <= n3_ty.v;
            r3_sat  <= r2_sat | n3_r4.sat | n3_k1r2.sat | n3_tx.sat | n3_ty.sat;

            r4_x     <= r3_x;
            r4_y     <= r3_y;
            r4_r6    <= n4_r6.v;
            r4_k2r4  <= n4_k2r4.v;
            r4_rad1  <= n4_rad1.v;
            r4_p1txy <= n4_p1txy.v;
            r4_p2tx  <= n4_p2tx.v;
            r4_p1ty  <= n4_p1ty.v;
            r4_p2txy <= n4_p2txy.v;
            r4_sat   <= r3_sat | n4_r6.sat | n4_k2r4.sat | n4_rad1.sat | n4_p1txy.sat
                      | n4_p2tx.sat | n4_p1ty.sat | n4_p2txy.sat;

            r5_x     <= r4_x;
            r5_y     <= r4_y;
            r5_k3r6  <= n5_k3r6.v;
            r5_rad2  <= n5_rad2.v;
            r5_p1txy <= r4_p1txy;
            r5_p2tx  <= r4_p2tx;
            r5_p1ty  <= r4_p1ty;
            r5_p2txy <= r4_p2txy;
            r5_sat   <= r4_sat | n5_k3r6.sat | n5_rad2.sat;

            r6_x     <= r5_x;
            r6_y     <= r5_y;
            r6_rad   <= n6_rad.v;
            r6_p1txy <= r5_p1txy;
            r6_p2tx  <= r5_p2tx;
            r6_p1ty  <= r5_p1ty;
            r6_p2txy <= r5_p2txy;
            r6_sat   <= r5_sat | n6_rad.sat;

            r7_xr    <= n7_xr.v;
            r7_yr    <= n7_yr.v;
            r7_p1txy <= r6_p1txy;
            r7_p2tx  <= r6_p2tx;
            r7_p1ty  <= r6_p1ty;
            r7_p2txy <= r6_p2txy;
            r7_sat   <= r6_sat | n7_xr.sat | n7_yr.sat;

            r8_xd  <= n8_xd.v;
            r8_yd  <= n8_yd.v;
            r8_sat <= r7_sat | n8_xa.sat | n8_xd.sat | n8_ya.sat | n8_yd.sat;
        end
    end

    assign o_xd  = r8_xd;
    assign o_yd  = r8_yd;
    assign o_sat = r8_sat;

endmodule

`default_nettype wire

// ----- design/lens_distortion_point_map.sv -----
// ----------------------------------------------------------------------------
// lens_distortion_point_map
// Maps an undistorted pixel point to its distorted position under the
// five-coefficient radial and tangential lens model.
//
//   port group   direction  handshake            payload
//   request in   in         i_valid / o_stall    i_req  (t_in_req)
//   request out  out        o_valid / i_stall    o_req  (t_out_req)
//   config       in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// one request per cycle unless i_stall freezes the pipeline
// the pipeline holds the 32-step pipelined divider (8 stages) and the
// multiply chain of the polynomial (8 stages) plus 2 projection stages
// synchronous active-low reset clears valid bits and loads config defaults
// i_stall with a full output register freezes the whole pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module lens_distortion_point_map (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  ldpm_pkg::t_in_req       i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ldpm_pkg::t_out_req      o_req,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);

    logic [31:0] r_focal_x, r_focal_y;
    logic [63:0] r_pp;
    ldpm_pkg::t_coef r_coef;

    logic r_vld [0:ldpm_pkg::TOTAL_LATENCY-1];
    logic en;

    ldpm_pkg::t_q nx, ny;
    logic signed [31:0] xd, yd;
    logic poly_sat;

    logic signed [64:0] n_px, n_py;
    logic signed [36:0] r_px, r_py;
    logic r_psat;
    ldpm_pkg::t_q n_ox, n_oy;
    ldpm_pkg::t_out_req r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= ldpm_pkg::FOCAL_RESET;
            r_focal_y <= ldpm_pkg::FOCAL_RESET;
            r_pp      <= ldpm_pkg::PP_RESET;
            r_coef    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ldpm_pkg::CFG_FOCAL_X: r_focal_x <= i_cfg_data[31:0];
                ldpm_pkg::CFG_FOCAL_Y: r_focal_y <= i_cfg_data[31:0];
                ldpm_pkg::CFG_PP:      r_pp      <= i_cfg_data;
                ldpm_pkg::CFG_K1:      r_coef.k1 <= i_cfg_data[31:0];
                ldpm_pkg::CFG_K2:      r_coef.k2 <= i_cfg_data[31:0];
                ldpm_pkg::CFG_K3:      r_coef.k3 <= i_cfg_data[31:0];
                ldpm_pkg::CFG_P1:      r_coef.p1 <= i_cfg_data[31:0];
                ldpm_pkg::CFG_P2:      r_coef.p2 <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign en      = !r_vld[ldpm_pkg::TOTAL_LATENCY-1] || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ldpm_pkg::TOTAL_LATENCY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < ldpm_pkg::TOTAL_LATENCY; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    ldpm_norm u_norm_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_in  (i_req.in_x),
        .i_c   (r_pp[31:0]),
        .i_f   (r_focal_x),
        .o_q   (nx)
    );

    ldpm_norm u_norm_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_in  (i_req.in_y),
        .i_c   (r_pp[63:32]),
        .i_f   (r_focal_y),
        .o_q   (ny)
    );

    ldpm_poly u_poly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (nx.v),
        .i_y    (ny.v),
        .i_sat  (nx.sat | ny.sat),
        .i_coef (r_coef),
        .o_xd   (xd),
        .o_yd   (yd),
        .o_sat  (poly_sat)
    );

    // projection back to pixels
    always_comb begin
        n_px = xd * $signed({1'b0, r_focal_x});
        n_py = yd * $signed({1'b0, r_focal_y});
        n_ox = ldpm_pkg::sat32({{3{r_px[36]}}, r_px} + 40'({8'b0, r_pp[31:0]}));
        n_oy = ldpm_pkg::sat32({{3{r_py[36]}}, r_py} + 40'({8'b0, r_pp[63:32]}));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px            <= n_px[64:28];
            r_py            <= n_py[64:28];
            r_psat          <= poly_sat;
            r_out.out_x     <= n_ox.v;
            r_out.out_y     <= n_oy.v;
            r_out.saturated <= r_psat | n_ox.sat | n_oy.sat;
        end
    end

    assign o_valid = r_vld[ldpm_pkg::TOTAL_LATENCY-1];
    assign o_req   = r_out;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a blocked output");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request not tracked");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_vld[0]) && $stable(r_out)))
        else $error("pipeline moved while frozen");
`endif

endmodule

`default_nettype wire
